// ----- design/wildcard_byte_signature_scanner_macros.svh -----
// Assertion macros for the wildcard byte signature scanner.
// Included by the top level; no other dependencies.
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define WBSS_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("wbss check failed in same cycle");

// The consequent holds in the cycle after the antecedent.
`define WBSS_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("wbss check failed in next cycle");

`endif

// ----- design/wbss_pkg.sv -----
// Package for the wildcard byte signature scanner.
// Holds parameter defaults, register indexes and fixed field widths; no dependencies.
`default_nettype none

package wbss_pkg;

  localparam int MAX_SIGNATURE_DEFAULT = 16;
  localparam int ADDRESS_WIDTH_DEFAULT = 32;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int SIG_LEN_WIDTH   = 5;
  localparam int MASK_WIDTH      = 16;
  localparam int OUT_ADDR_WIDTH  = 32;
  localparam int COUNT_WIDTH     = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIGNATURE_LOW  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIGNATURE_HIGH = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WILDCARD_MASK  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIG_LENGTH     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_ADDRESS   = 3'd4;

endpackage

`default_nettype wire

// ----- design/wildcard_byte_signature_scanner.sv -----
// An accepted image byte passes through the input register, then the result register.
// Throughput: one image byte per cycle while in_stall is low; the output register
// frees the input side. The match compare is combinational between the two registers.
// Reset (rst, synchronous, active high) restores register defaults, clears the
// byte counter, the done flag and both pipeline valid bits.
// Depends on wbss_pkg and wildcard_byte_signature_scanner_macros.svh.
`default_nettype none

`include "wildcard_byte_signature_scanner_macros.svh"

module wildcard_byte_signature_scanner #(
  parameter int MAX_SIGNATURE = wbss_pkg::MAX_SIGNATURE_DEFAULT,
  parameter int ADDRESS_WIDTH = wbss_pkg::ADDRESS_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_write,
  input  wire logic [wbss_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [wbss_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [7:0]                             image_byte,
  input  wire logic                                   first_of_image,
  input  wire logic                                   last_of_image,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        found,
  output logic [wbss_pkg::OUT_ADDR_WIDTH-1:0]         match_address
);

  localparam int LenW = $clog2(MAX_SIGNATURE + 1);
  localparam int IdxW = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;
  localparam int CntW = wbss_pkg::COUNT_WIDTH;

  logic [63:0] signature_low;
  logic [63:0] signature_high;
  logic [wbss_pkg::MASK_WIDTH-1:0] wildcard_mask;
  logic [wbss_pkg::SIG_LEN_WIDTH-1:0] signature_length;
  logic [31:0] base_address;

  logic [7:0] window [MAX_SIGNATURE];
  logic [7:0] window_next [MAX_SIGNATURE];
  logic [CntW-1:0] bytes_seen;
  logic scan_done;

  logic s1_valid;
  logic [7:0] s1_byte;
  logic s1_first;
  logic s1_last;
  logic s1_fire;

  logic [CntW-1:0] seen_cur;
  logic [CntW-1:0] seen_next;
  logic done_cur;
  logic [LenW-1:0] len_eff;
  logic [127:0] sig_all;
  logic bytes_match;
  logic is_match;
  logic has_result;
  logic [CntW-1:0] offset;
  logic [ADDRESS_WIDTH-1:0] addr_sum;
  logic [63:0] addr_wide;
  logic [LenW-1:0] pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      signature_low    <= '0;
      signature_high   <= '0;
      wildcard_mask    <= '0;
      signature_length <= wbss_pkg::SIG_LEN_WIDTH'(1);
      base_address     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wbss_pkg::REG_SIGNATURE_LOW:  signature_low <= cfg_data;
        wbss_pkg::REG_SIGNATURE_HIGH: signature_high <= cfg_data;
        wbss_pkg::REG_WILDCARD_MASK:  wildcard_mask <= cfg_data[wbss_pkg::MASK_WIDTH-1:0];
        wbss_pkg::REG_SIG_LENGTH:     signature_length <= cfg_data[wbss_pkg::SIG_LEN_WIDTH-1:0];
        wbss_pkg::REG_BASE_ADDRESS:   base_address <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte  <= image_byte;
      s1_first <= first_of_image;
      s1_last  <= last_of_image;
    end
  end

  always_comb begin
    if (signature_length == '0) begin
      len_eff = LenW'(1);
    end else if (32'(signature_length) > 32'(MAX_SIGNATURE)) begin
      len_eff = LenW'(MAX_SIGNATURE);
    end else begin
      len_eff = LenW'(signature_length);
    end
  end

  assign sig_all  = {signature_high, signature_low};
  assign seen_cur = s1_first ? '0 : bytes_seen;
  assign done_cur = s1_first ? 1'b0 : scan_done;
  assign seen_next = (seen_cur == '1) ? seen_cur : seen_cur + CntW'(1);

  always_comb begin
    window_next[0] = s1_byte;
    for (int k = 1; k < MAX_SIGNATURE; k++) begin
      window_next[k] = window[k-1];
    end
  end

  always_comb begin
    bytes_match = 1'b1;
    pos = '0;
    for (int j = 0; j < MAX_SIGNATURE; j++) begin
      if (LenW'(j) < len_eff) begin
        pos = len_eff - LenW'(1) - LenW'(j);
        if (!wildcard_mask[j] && window_next[pos[IdxW-1:0]] != sig_all[8*j +: 8]) begin
          bytes_match = 1'b0;
        end
      end
    end
  end

  assign is_match   = !done_cur && (seen_next >= CntW'(len_eff)) && bytes_match;
  assign has_result = !done_cur && (is_match || s1_last);
  assign offset     = seen_next - CntW'(len_eff);
  assign addr_sum   = ADDRESS_WIDTH'(64'(base_address)) + ADDRESS_WIDTH'(64'(offset));
  assign addr_wide  = 64'(addr_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      scan_done  <= 1'b0;
    end else if (s1_fire) begin
      bytes_seen <= done_cur ? seen_cur : seen_next;
      scan_done  <= done_cur || has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && !done_cur) begin
      for (int k = 0; k < MAX_SIGNATURE; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      found         <= is_match;
      match_address <= is_match ? addr_wide[31:0] : '1;
    end
  end

  `WBSS_ASSERT_SAME(a_not_found_all_ones, clk, rst, out_valid && !found, match_address == '1)
  `WBSS_ASSERT_NEXT(a_result_sets_done, clk, rst, s1_fire && has_result, scan_done)
  `WBSS_ASSERT_NEXT(a_result_reaches_output, clk, rst, s1_fire && has_result, out_valid)

endmodule

`default_nettype wire
